@@ design/lprf_pkg.sv @@
// Package for the lidar ROI filter: widths, word types, limit tables and helpers.
`default_nettype none
package lprf_pkg;

   localparam int COORD_WIDTH  = 20;
   localparam int INTENSITY_W  = 16;
   localparam int SPEED_W      = 8;
   localparam int SPEED_LEVELS = 1 << SPEED_W;

   // past the radius test |a|, |z|, |rot_y| stay below 2^19
   localparam int MAG_W    = 19;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int B_W      = 14;
   localparam int BSQ_W    = 2 * B_W;
   localparam int RX_W     = 14;
   localparam int RXSQ_W   = 2 * RX_W;
   localparam int RHO2_W   = SQ_W + 1;
   localparam int DIST2_W  = SQ_W + 2;
   localparam int RAD2_W   = 38;
   localparam int TAN2_W   = 24;
   localparam int TAN2_FRAC = 24;
   localparam int PROD_W   = 64;

   localparam int SPLIT_A  = 19;
   localparam int P40_LO_W = TAN2_W + SPLIT_A;
   localparam int P40_HI_W = TAN2_W + SQ_W - SPLIT_A;
   localparam int SPLIT_R  = 20;
   localparam int PE_LO_W  = TAN2_W + SPLIT_R;
   localparam int PE_HI_W  = TAN2_W + RHO2_W - SPLIT_R;

   localparam int EXT_W = (COORD_WIDTH + 2 > MAG_W + 1) ? COORD_WIDTH + 2 : MAG_W + 1;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] CX_MM     = COORD_WIDTH'(2500);
   localparam logic signed [COORD_WIDTH-1:0] XMIN_MM   = COORD_WIDTH'(-13000);
   localparam logic signed [EXT_W-1:0]       A_OFS_MM  = EXT_W'(5000);
   localparam logic [EXT_W-1:0]              MAG_MAX   = EXT_W'((1 << MAG_W) - 1);

   localparam int ELEV_KNEE_SPEED = 60;
   localparam int ELEV_LIM_LOW    = 225;
   localparam int ELEV_LIM_BASE   = 95;
   localparam int FOUR_DEG_TENTHS = 40;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic [INTENSITY_W-1:0]        point_intensity;
      logic                          frame_end;
   } req_word_type;

   typedef struct packed {
      logic                          keep;
      logic signed [COORD_WIDTH-1:0] rot_x;
      logic signed [COORD_WIDTH-1:0] rot_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic [INTENSITY_W-1:0]        out_intensity;
      logic                          out_frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [RAD2_W-1:0] rad2;
      logic [TAN2_W-1:0] elev_tan2;
      logic              elev_neg;
   } cfg_type;

   typedef struct packed {
      rsp_word_type     word;
      logic             a_pos;
      logic             a_neg;
      logic             z_pos;
      logic             z_neg;
      logic [MAG_W-1:0] mag_a;
      logic [MAG_W-1:0] mag_z;
      logic [MAG_W-1:0] mag_ry;
      logic [B_W-1:0]   mag_b;
      logic [RX_W-1:0]  mag_rx;
   } geom_type;

   typedef struct packed {
      rsp_word_type      word;
      logic              a_pos;
      logic              a_neg;
      logic              z_pos;
      logic              z_neg;
      logic [SQ_W-1:0]   a2;
      logic [SQ_W-1:0]   z2;
      logic [SQ_W-1:0]   ry2;
      logic [BSQ_W-1:0]  b2;
      logic [RXSQ_W-1:0] rx2;
   } square_type;

   typedef struct packed {
      rsp_word_type        word;
      logic                a_pos;
      logic                z_pos;
      logic                z_neg;
      logic [BSQ_W-1:0]    b2;
      logic [SQ_W-1:0]     z2;
      logic [RHO2_W-1:0]   rho2;
      logic [P40_LO_W-1:0] p40_lo;
      logic [P40_HI_W-1:0] p40_hi;
   } combine_type;

   typedef struct packed {
      rsp_word_type       word;
      logic               z_pos;
      logic               z_neg;
      logic [SQ_W-1:0]    z2;
      logic [PE_LO_W-1:0] pe_lo;
      logic [PE_HI_W-1:0] pe_hi;
   } elev_type;

   typedef logic [SPEED_LEVELS-1:0][RAD2_W-1:0] rad2_rom_type;
   typedef logic [SPEED_LEVELS-1:0][TAN2_W-1:0] tan2_rom_type;
   typedef logic [SPEED_LEVELS-1:0]             neg_rom_type;

   // restoring long division, table construction only
   function automatic logic [63:0] udiv_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo, rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tan^2 of t tenths of a degree, Q24, truncated Taylor series in Q30
   function automatic logic [63:0] tan2_q24(input int t);
      logic [63:0] th, th2, s, st, c, ct;
      th  = (64'(t) * PI_Q30) / 64'd1800;
      th2 = (th * th) >> 30;
      s   = th;
      st  = th;
      c   = 64'd1 << 30;
      ct  = c;
      st  = ((st * th2) >> 30) / 64'd6;
      ct  = ((ct * th2) >> 30) / 64'd2;
      s   = s - st;
      c   = c - ct;
      st  = ((st * th2) >> 30) / 64'd20;
      ct  = ((ct * th2) >> 30) / 64'd12;
      s   = s + st;
      c   = c + ct;
      st  = ((st * th2) >> 30) / 64'd42;
      ct  = ((ct * th2) >> 30) / 64'd30;
      s   = s - st;
      c   = c - ct;
      st  = ((st * th2) >> 30) / 64'd72;
      ct  = ((ct * th2) >> 30) / 64'd56;
      s   = s + st;
      c   = c + ct;
      return udiv_u64(s * s, (c * c) >> 24);
   endfunction

   // elevation limit in tenths of a degree
   function automatic int elev_limit(input int speed);
      return (speed < ELEV_KNEE_SPEED) ? ELEV_LIM_LOW
                                       : ELEV_LIM_BASE - 2 * (speed - ELEV_KNEE_SPEED);
   endfunction

   function automatic rad2_rom_type build_rad2_rom();
      rad2_rom_type rom;
      logic [63:0]  rm;
      for (int s = 0; s < SPEED_LEVELS; s++) begin
         rm     = 64'(((9 * s + 2) / 5) * 1000);
         rom[s] = RAD2_W'(rm * rm);
      end
      return rom;
   endfunction

   function automatic tan2_rom_type build_tan2_rom();
      tan2_rom_type rom;
      int           lim;
      for (int s = 0; s < SPEED_LEVELS; s++) begin
         lim    = elev_limit(s);
         rom[s] = TAN2_W'(tan2_q24((lim < 0) ? -lim : lim));
      end
      return rom;
   endfunction

   function automatic neg_rom_type build_neg_rom();
      neg_rom_type rom;
      for (int s = 0; s < SPEED_LEVELS; s++) begin
         rom[s] = (elev_limit(s) < 0);
      end
      return rom;
   endfunction

   localparam rad2_rom_type      RAD2_ROM      = build_rad2_rom();
   localparam tan2_rom_type      ELEV_TAN2_ROM = build_tan2_rom();
   localparam neg_rom_type       ELEV_NEG_ROM  = build_neg_rom();
   localparam logic [TAN2_W-1:0] TAN2_FOUR_DEG = TAN2_W'(tan2_q24(FOUR_DEG_TENTHS));
   localparam cfg_type CFG_RESET = '{rad2:      RAD2_ROM[0],
                                     elev_tan2: ELEV_TAN2_ROM[0],
                                     elev_neg:  ELEV_NEG_ROM[0]};

   // magnitude clamped to MAG_W bits; a clamped value always fails the radius
   function automatic logic [MAG_W-1:0] sat_mag(input logic [EXT_W-1:0] v);
      return (v > MAG_MAX) ? {MAG_W{1'b1}} : v[MAG_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ design/lidar_point_roi_filter.sv @@
// Top level of the lidar ROI filter: speed register, stall control and five-stage pipeline.
//
//   port group  dir  handshake                  word
//   req_        in   req_valid / req_stall      req_word_type (point_x/y/z, intensity, frame_end)
//   rsp_        out  rsp_valid / rsp_stall      rsp_word_type (keep, rot_x/y, out_z, ...)
//   csr_        in   csr_valid / csr_ready      csr_data, vehicle speed in km/h
//
// One word per cycle while no stalled result is held; each word passes through the five register stages.
// Synchronous reset empties the pipeline and sets the speed to zero.
// A stalled result freezes every stage at once; req_stall is rsp_stall gated by rsp_valid.
// csr_ready is always high; the speed tables are looked up on the write.
`default_nettype none
module lidar_point_roi_filter import lprf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic             req_stall,
   input  wire req_word_type req_word,
   output logic             rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type     rsp_word,
   input  wire logic         csr_valid,
   output logic             csr_ready,
   input  wire logic [SPEED_W-1:0] csr_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        advance;
   logic        geom_valid, square_valid, combine_valid;
   geom_type    geom;
   square_type  square;
   combine_type combine;

   always_comb begin
      cfg_in.rad2      = RAD2_ROM[csr_data];
      cfg_in.elev_tan2 = ELEV_TAN2_ROM[csr_data];
      cfg_in.elev_neg  = ELEV_NEG_ROM[csr_data];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   lprf_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (geom_valid),
      .out_geom  (geom)
   );

   lprf_square u_square (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (geom_valid),
      .in_geom    (geom),
      .out_valid  (square_valid),
      .out_square (square)
   );

   lprf_combine u_combine (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cfg         (cfg_ff),
      .in_valid    (square_valid),
      .in_square   (square),
      .out_valid   (combine_valid),
      .out_combine (combine)
   );

   lprf_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cfg        (cfg_ff),
      .in_valid   (combine_valid),
      .in_combine (combine),
      .out_valid  (rsp_valid),
      .out_word   (rsp_word)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> geom_valid)
      else $error("accepted word did not enter stage 1");

   a_keep_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.keep |-> rsp_word.rot_x != '0 &&
         rsp_word.rot_x >= XMIN_MM && rsp_word.rot_x <= CX_MM)
      else $error("kept point with rot_x outside the window");

   a_rot_y_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.rot_y != COORD_MIN)
      else $error("rot_y not saturated");

endmodule
`default_nettype wire

@@ design/lprf_geom.sv @@
// Stage 1: rotation, x range test, offsets and clamped magnitudes.
`default_nettype none
module lprf_geom import lprf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         in_valid,
   input  wire req_word_type in_word,
   output logic             out_valid,
   output geom_type         out_geom
);

   logic                          valid_ff;
   geom_type                      geom_ff, geom_in;
   logic signed [COORD_WIDTH-1:0] rx, ry;
   logic signed [EXT_W-1:0]       a_ext, z_ext, ry_ext;
   logic [EXT_W-1:0]              abs_a, abs_z, abs_ry;

   always_comb begin
      rx     = in_word.point_y;
      ry     = (in_word.point_x == COORD_MIN) ? COORD_MAX : -in_word.point_x;
      ry_ext = EXT_W'(ry);
      z_ext  = EXT_W'(in_word.point_z);
      a_ext  = ry_ext + A_OFS_MM;
      abs_a  = a_ext[EXT_W-1]  ? -a_ext  : a_ext;
      abs_z  = z_ext[EXT_W-1]  ? -z_ext  : z_ext;
      abs_ry = ry_ext[EXT_W-1] ? -ry_ext : ry_ext;

      geom_in.word.keep          = (rx >= XMIN_MM) && (rx <= CX_MM) && (rx != '0);
      geom_in.word.rot_x         = rx;
      geom_in.word.rot_y         = ry;
      geom_in.word.out_z         = in_word.point_z;
      geom_in.word.out_intensity = in_word.point_intensity;
      geom_in.word.out_frame_end = in_word.frame_end;
      geom_in.a_pos  = !a_ext[EXT_W-1] && (a_ext != '0);
      geom_in.a_neg  = a_ext[EXT_W-1];
      geom_in.z_pos  = !z_ext[EXT_W-1] && (z_ext != '0);
      geom_in.z_neg  = z_ext[EXT_W-1];
      geom_in.mag_a  = sat_mag(abs_a);
      geom_in.mag_z  = sat_mag(abs_z);
      geom_in.mag_ry = sat_mag(abs_ry);
      // only meaningful while rot_x is in range
      geom_in.mag_b  = B_W'(CX_MM - rx);
      geom_in.mag_rx = rx[COORD_WIDTH-1] ? RX_W'(-rx) : RX_W'(rx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         geom_ff <= geom_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_geom  = geom_ff;

endmodule
`default_nettype wire

@@ design/lprf_square.sv @@
// Stage 2: squares of the offsets and coordinates.
`default_nettype none
module lprf_square import lprf_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     in_valid,
   input  wire geom_type in_geom,
   output logic         out_valid,
   output square_type   out_square
);

   logic       valid_ff;
   square_type square_ff, square_in;

   always_comb begin
      square_in.word  = in_geom.word;
      square_in.a_pos = in_geom.a_pos;
      square_in.a_neg = in_geom.a_neg;
      square_in.z_pos = in_geom.z_pos;
      square_in.z_neg = in_geom.z_neg;
      square_in.a2    = SQ_W'(in_geom.mag_a)  * SQ_W'(in_geom.mag_a);
      square_in.z2    = SQ_W'(in_geom.mag_z)  * SQ_W'(in_geom.mag_z);
      square_in.ry2   = SQ_W'(in_geom.mag_ry) * SQ_W'(in_geom.mag_ry);
      square_in.b2    = BSQ_W'(in_geom.mag_b) * BSQ_W'(in_geom.mag_b);
      square_in.rx2   = RXSQ_W'(in_geom.mag_rx) * RXSQ_W'(in_geom.mag_rx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         square_ff <= square_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_square = square_ff;

endmodule
`default_nettype wire

@@ design/lprf_combine.sv @@
// Stage 3: radius and 150 degree tests, rho^2, partial products of the 4 degree test.
`default_nettype none
module lprf_combine import lprf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   input  wire square_type in_square,
   output logic           out_valid,
   output combine_type    out_combine
);

   logic               valid_ff;
   combine_type        combine_ff, combine_in;
   logic [DIST2_W-1:0] dist2;
   logic [SQ_W-1:0]    b2_x3;
   logic               rad_ok, cone_fail;

   always_comb begin
      dist2 = DIST2_W'(in_square.a2) + DIST2_W'(in_square.b2) + DIST2_W'(in_square.z2);
      rad_ok = dist2 <= DIST2_W'(cfg.rad2);
      b2_x3 = (SQ_W'(in_square.b2) << 1) + SQ_W'(in_square.b2);
      cone_fail = in_square.a_neg && (b2_x3 < in_square.a2);

      combine_in.word      = in_square.word;
      combine_in.word.keep = in_square.word.keep && rad_ok && !cone_fail;
      combine_in.a_pos     = in_square.a_pos;
      combine_in.z_pos     = in_square.z_pos;
      combine_in.z_neg     = in_square.z_neg;
      combine_in.b2        = in_square.b2;
      combine_in.z2        = in_square.z2;
      combine_in.rho2      = RHO2_W'(in_square.rx2) + RHO2_W'(in_square.ry2);
      combine_in.p40_lo    = P40_LO_W'(TAN2_FOUR_DEG) * P40_LO_W'(in_square.a2[SPLIT_A-1:0]);
      combine_in.p40_hi    = P40_HI_W'(TAN2_FOUR_DEG) *
                             P40_HI_W'(in_square.a2[SQ_W-1:SPLIT_A]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         combine_ff <= combine_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_combine = combine_ff;

endmodule
`default_nettype wire

@@ design/lprf_decide.sv @@
// Stages 4 and 5: 4 degree test, elevation products and compare, output register.
`default_nettype none
module lprf_decide import lprf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   input  wire combine_type in_combine,
   output logic            out_valid,
   output rsp_word_type    out_word
);

   logic              elev_valid_ff, word_valid_ff;
   elev_type          elev_ff, elev_in;
   rsp_word_type      word_ff, word_in;
   logic [PROD_W-1:0] four_lhs, four_rhs, elev_lhs, elev_rhs;
   logic              four_fail, elev_ok;

   always_comb begin
      four_lhs  = PROD_W'(in_combine.b2) << TAN2_FRAC;
      four_rhs  = (PROD_W'(in_combine.p40_hi) << SPLIT_A) + PROD_W'(in_combine.p40_lo);
      four_fail = in_combine.a_pos && (four_lhs < four_rhs);

      elev_in.word      = in_combine.word;
      elev_in.word.keep = in_combine.word.keep && !four_fail;
      elev_in.z_pos     = in_combine.z_pos;
      elev_in.z_neg     = in_combine.z_neg;
      elev_in.z2        = in_combine.z2;
      elev_in.pe_lo     = PE_LO_W'(cfg.elev_tan2) * PE_LO_W'(in_combine.rho2[SPLIT_R-1:0]);
      elev_in.pe_hi     = PE_HI_W'(cfg.elev_tan2) *
                          PE_HI_W'(in_combine.rho2[RHO2_W-1:SPLIT_R]);
   end

   always_comb begin
      elev_lhs = PROD_W'(elev_ff.z2) << TAN2_FRAC;
      elev_rhs = (PROD_W'(elev_ff.pe_hi) << SPLIT_R) + PROD_W'(elev_ff.pe_lo);
      // negative limit: point must lie below the downward cone
      elev_ok  = cfg.elev_neg ? (elev_ff.z_neg && (elev_lhs >= elev_rhs))
                              : (!elev_ff.z_pos || (elev_lhs <= elev_rhs));
      word_in      = elev_ff.word;
      word_in.keep = elev_ff.word.keep && elev_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elev_valid_ff <= 1'b0;
         word_valid_ff <= 1'b0;
      end else if (advance) begin
         elev_valid_ff <= in_valid;
         word_valid_ff <= elev_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         elev_ff <= elev_in;
         word_ff <= word_in;
      end
   end

   assign out_valid = word_valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for lidar_point_roi_filter: directed and random points against a bit-exact predictor.
`timescale 1ns / 1ps
module tb_top import lprf_pkg::*; ();

   localparam int  SETTLE_CYCLES = 10;
   localparam int  LIMIT_CYCLES  = 200000;
   localparam int  ROI_X_MIN_MM  = -13000;
   localparam int  ROI_X_MAX_MM  = 2500;
   localparam int  CENTER_Y_MM   = -5000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_word_type        req_word  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_word_type        rsp_word;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SPEED_W-1:0]  csr_data  = '0;

   logic [SPEED_W-1:0]  speed_now = '0;
   rsp_word_type        predicted_words[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   bit                  send_idle   = 1'b1;
   bit                  recv_idle   = 1'b1;

   lidar_point_roi_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // tan^2 of an angle in tenths of a degree, Q24, from truncated Q30 series
   function automatic longint tan_sq_q24(input int tenths);
      logic [63:0] ang, ang2, sn, sterm, cs, cterm;
      ang   = (64'(tenths) * PI_Q30) / 64'd1800;
      ang2  = (ang * ang) >> 30;
      sn    = ang;
      sterm = ang;
      cs    = 64'd1 << 30;
      cterm = cs;
      for (int k = 1; k <= 4; k++) begin
         sterm = ((sterm * ang2) >> 30) / 64'(2 * k * (2 * k + 1));
         cterm = ((cterm * ang2) >> 30) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            sn = sn - sterm;
            cs = cs - cterm;
         end else begin
            sn = sn + sterm;
            cs = cs + cterm;
         end
      end
      return longint'((sn * sn) / ((cs * cs) >> 24));
   endfunction

   function automatic rsp_word_type filter_point(input req_word_type w,
                                                 input logic [SPEED_W-1:0] speed);
      longint       px, rx, ry, pz, a, b, a2, b2, z2, rm, rho2, t2;
      int           spd, lim;
      bit           ok;
      rsp_word_type r;
      spd = int'(speed);
      px  = longint'($signed(w.point_x));
      rx  = longint'($signed(w.point_y));
      pz  = longint'($signed(w.point_z));
      ry  = (px == longint'(COORD_MIN)) ? longint'(COORD_MAX) : -px;
      ok  = !(rx < ROI_X_MIN_MM || rx > ROI_X_MAX_MM || rx == 0);
      if (ok) begin
         a  = ry - CENTER_Y_MM;
         b  = rx - ROI_X_MAX_MM;
         a2 = a * a;
         b2 = b * b;
         z2 = pz * pz;
         rm = longint'(((9 * spd + 2) / 5) * 1000);
         if (a2 + b2 + z2 > rm * rm)
            ok = 1'b0;
         if (ok && a > 0 && (b2 << 24) < tan_sq_q24(FOUR_DEG_TENTHS) * a2)
            ok = 1'b0;
         if (ok && a < 0 && 3 * b2 < a2)
            ok = 1'b0;
         if (ok) begin
            lim  = (spd < ELEV_KNEE_SPEED) ? ELEV_LIM_LOW
                                           : ELEV_LIM_BASE - 2 * (spd - ELEV_KNEE_SPEED);
            rho2 = rx * rx + ry * ry;
            if (lim == 0) begin
               ok = (pz <= 0);
            end else if (lim > 0) begin
               t2 = tan_sq_q24(lim);
               ok = (pz <= 0) || ((z2 << 24) <= t2 * rho2);
            end else begin
               t2 = tan_sq_q24(-lim);
               ok = (pz < 0) && ((z2 << 24) >= t2 * rho2);
            end
         end
      end
      r.keep          = ok;
      r.rot_x         = COORD_WIDTH'(rx);
      r.rot_y         = COORD_WIDTH'(ry);
      r.out_z         = w.point_z;
      r.out_intensity = w.point_intensity;
      r.out_frame_end = w.frame_end;
      return r;
   endfunction

   function automatic req_word_type rotated_point(input int rot_x, input int rot_y,
                                                  input int z, input int inten, input bit last);
      req_word_type w;
      w.point_x         = COORD_WIDTH'(-rot_y);
      w.point_y         = COORD_WIDTH'(rot_x);
      w.point_z         = COORD_WIDTH'(z);
      w.point_intensity = INTENSITY_W'(inten);
      w.frame_end       = last;
      return w;
   endfunction

   function automatic req_word_type random_point();
      req_word_type w;
      logic [95:0]  raw;
      int           radius, span, sel, rx, ry, z, reach;
      radius = ((9 * int'(speed_now) + 2) / 5) * 1000;
      span   = radius + 2000;
      sel    = $urandom_range(0, 99);
      if (sel < 20) begin
         raw = {$urandom, $urandom, $urandom};
         w   = raw[$bits(req_word_type)-1:0];
         return w;
      end
      if (sel < 35) begin
         case ($urandom_range(0, 6))
            0: rx = ROI_X_MIN_MM - 1;
            1: rx = ROI_X_MIN_MM;
            2: rx = 0;
            3: rx = ROI_X_MAX_MM;
            4: rx = ROI_X_MAX_MM + 1;
            5: rx = 1;
            default: rx = -1;
         endcase
      end else begin
         rx = int'($urandom_range(0, 16000)) - 13250;
      end
      ry = CENTER_Y_MM + int'($urandom_range(0, 2 * span)) - span;
      if (ry > 524287)
         ry = 524287;
      if (ry < -524287)
         ry = -524287;
      reach = ((ry < 0 ? -ry : ry) + (rx < 0 ? -rx : rx)) * 3 / 5 + 10;
      z = int'($urandom_range(0, reach));
      if ($urandom_range(0, 1))
         z = -z;
      w = rotated_point(rx, ry, z, int'($urandom), $urandom_range(0, 1) != 0);
      if (ry == 524287 && $urandom_range(0, 1))
         w.point_x = COORD_MIN;
      return w;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("mismatch @%0t: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] got,
                                input logic signed [63:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      if (predicted_words.size() == 0) begin
         report_error("result word with none outstanding");
         return;
      end
      want = predicted_words.pop_front();
      compare_field("keep", 64'(got.keep), 64'(want.keep));
      compare_field("rot_x", 64'($signed(got.rot_x)), 64'($signed(want.rot_x)));
      compare_field("rot_y", 64'($signed(got.rot_y)), 64'($signed(want.rot_y)));
      compare_field("out_z", 64'($signed(got.out_z)), 64'($signed(want.out_z)));
      compare_field("out_intensity", 64'(got.out_intensity), 64'(want.out_intensity));
      compare_field("out_frame_end", 64'(got.out_frame_end), 64'(want.out_frame_end));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_result(rsp_word);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side back-pressure, drawn per word
   initial begin
      int hold;
      do @(posedge clock); while (reset);
      forever begin
         hold = recv_idle ? $urandom_range(0, 9) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_point(input req_word_type w);
      int gap;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted_words.insert(predicted_words.size(), filter_point(w, speed_now));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (predicted_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_speed(input logic [SPEED_W-1:0] speed);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= speed;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      speed_now = speed;
   endtask

   // speed zero after reset: only the exact center survives
   task automatic test_reset_speed();
      req_word_type w;
      send_point(rotated_point(ROI_X_MAX_MM, CENTER_Y_MM, 0, 16'h1234, 1'b0));
      send_point(rotated_point(ROI_X_MAX_MM, CENTER_Y_MM, 1, 16'h4321, 1'b1));
      w = {COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000, 1'b0};
      send_point(w);
      w = {COORD_MAX, COORD_MAX, COORD_MAX, 16'hffff, 1'b1};
      send_point(w);
   endtask

   task automatic test_roi_borders();
      set_speed(8'd255);
      send_point(rotated_point(0, -20000, 0, 1, 1'b0));
      send_point(rotated_point(ROI_X_MIN_MM, -20000, 0, 2, 1'b0));
      send_point(rotated_point(ROI_X_MIN_MM - 1, -20000, 0, 3, 1'b0));
      send_point(rotated_point(ROI_X_MAX_MM, -20000, 0, 4, 1'b0));
      send_point(rotated_point(ROI_X_MAX_MM + 1, -20000, 0, 5, 1'b1));
      // four degree edge, a = 10000
      send_point(rotated_point(ROI_X_MAX_MM - 700, 5000, 0, 6, 1'b0));
      send_point(rotated_point(ROI_X_MAX_MM - 699, 5000, 0, 7, 1'b0));
      // 150 degree edge, a = -10000
      send_point(rotated_point(ROI_X_MAX_MM - 5774, -15000, 0, 8, 1'b0));
      send_point(rotated_point(ROI_X_MAX_MM - 5773, -15000, 0, 9, 1'b0));
      // negative elevation limit: only points well below pass
      send_point(rotated_point(-1000, 0, -1000, 10, 1'b0));
      send_point(rotated_point(-1000, 0, -500, 11, 1'b0));
      send_point(rotated_point(-1000, 0, 100, 12, 1'b1));
   endtask

   task automatic test_radius_edge();
      set_speed(8'd5);
      send_point(rotated_point(-6500, CENTER_Y_MM, 0, 13, 1'b0));
      send_point(rotated_point(-6500, CENTER_Y_MM, -1, 14, 1'b1));
   endtask

   task automatic test_elevation_knee();
      set_speed(8'd59);
      send_point(rotated_point(-1000, 0, 400, 15, 1'b0));
      send_point(rotated_point(-1000, 0, 420, 16, 1'b1));
   endtask

   task automatic test_random_speeds();
      logic [SPEED_W-1:0] speeds[10];
      speeds = '{8'd255, 8'd0, 8'd59, 8'd60, 8'd107, 8'd108, 8'd1, 8'd200, 8'd0, 8'd0};
      speeds[8] = SPEED_W'($urandom_range(0, 255));
      speeds[9] = SPEED_W'($urandom_range(0, 255));
      for (int r = 0; r < 10; r++) begin
         set_speed(speeds[r]);
         send_idle = (r % 3 != 1);
         recv_idle = (r % 4 != 2);
         repeat (135) send_point(random_point());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_speed();
      test_roi_borders();
      test_radius_edge();
      test_elevation_knee();
      test_random_speeds();
      drain_pipeline();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/lprf_pkg.sv
design/lprf_geom.sv
design/lprf_square.sv
design/lprf_combine.sv
design/lprf_decide.sv
design/lidar_point_roi_filter.sv
bench/tb_top.sv
